// ===== rtl/core/grid_bin_height_cutoff_filter_defines.svh =====
// Assertion helpers for the grid binning block.
`ifndef GRID_BIN_HEIGHT_CUTOFF_FILTER_DEFINES_SVH
`define GRID_BIN_HEIGHT_CUTOFF_FILTER_DEFINES_SVH

`ifndef ASSERT_OFF
// clocked check, masked while reset is held
`define GBH_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define GBH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GBH_ASSERT(lbl, clk, rst_n, prop, msg)
`define GBH_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/core/gbh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gbh_pkg;

    localparam int GRID_SIZE = 32;
    localparam int CELL_CAP  = 16;

    localparam int GRID_BITS = $clog2(GRID_SIZE);
    localparam int NCELLS    = GRID_SIZE * GRID_SIZE;
    localparam int CELL_AW   = 2 * GRID_BITS;
    localparam int CNT_W     = $clog2(CELL_CAP + 1);
    localparam int PT_DEPTH  = NCELLS * CELL_CAP;
    localparam int PT_AW     = $clog2(PT_DEPTH);

    // divider operand widths: offset coordinate and cell size
    localparam int DIV_NUM_W = 16;
    localparam int DIV_DEN_W = 15;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_POINT  = 2'd1,
        KIND_EMPTY  = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    localparam logic [1:0] INS_STORED = 2'd0;
    localparam logic [1:0] INS_REJECT = 2'd1;
    localparam logic [1:0] INS_FULL   = 2'd2;

    localparam logic [2:0] REG_X_LIMIT   = 3'd0;
    localparam logic [2:0] REG_Y_LIMIT   = 3'd1;
    localparam logic [2:0] REG_Z_FLOOR   = 3'd2;
    localparam logic [2:0] REG_Z_CEILING = 3'd3;
    localparam logic [2:0] REG_CELL_X    = 3'd4;
    localparam logic [2:0] REG_CELL_Y    = 3'd5;
    localparam logic [2:0] REG_FRACTION  = 3'd6;
    localparam logic [2:0] REG_MODE      = 3'd7;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_INS_CHK,
        S_INS_DIV,
        S_INS_UPD,
        S_RD_MUL,
        S_RD_ADD,
        S_RD_PT,
        S_RD_CHK,
        S_RD_FIN,
        S_CLR,
        S_CLR_DONE
    } state_t;

    typedef struct packed {
        logic [7:0]   inten;
        logic [15:0]  z;
        logic [15:0]  y;
        logic [15:0]  x;
    } pt_t;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [15:0]      hmax;
        logic [15:0]      hmin;
    } stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/gbh_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module gbh_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [gbh_pkg::DIV_NUM_W-1:0] num,
    input  wire logic [gbh_pkg::DIV_DEN_W-1:0] den,
    output logic                               done,
    output logic      [gbh_pkg::DIV_NUM_W-1:0] quo
);
    import gbh_pkg::*;

    localparam int STEP_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;

    // shift in next numerator bit, subtract when it fits
    always_comb begin
        trial = {rem_reg, quo_reg[DIV_NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        if (trial >= {1'b0, den_reg}) begin
            rem_next = diff[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b1};
        end else begin
            rem_next = trial[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
`default_nettype wire

// ===== rtl/core/grid_bin_height_cutoff_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Grid binning with per-cell height cutoff. One command word is handled at a time.
// An insert that passes the box check runs the two parallel bit-serial dividers,
// then the read-modify-write of the cell statistics memory. A read walks the
// stored points of the cell, one point memory read and check each. A clear
// sweeps the statistics memory, one cell a cycle, then emits the result.
// After reset the same sweep runs before the first word is accepted;
// configuration writes are taken throughout. Results leave through an output
// register, so a waiting result stalls only the next emission.
module grid_bin_height_cutoff_filter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: point_x, point_y, point_z, point_intensity, cell_row, cell_col
    input  wire logic [71:0] s_tdata,
    // s_tuser: command
    input  wire logic [1:0]  s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // m_tdata: status, bin_row, bin_col, out_x, out_y, out_z, out_intensity
    output logic      [71:0] m_tdata,
    // m_tuser: kind
    output logic      [1:0]  m_tuser,
    output logic             m_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);
    import gbh_pkg::*;

    `include "grid_bin_height_cutoff_filter_defines.svh"

    // configuration
    logic [14:0]        x_limit_reg, y_limit_reg, csx_reg, csy_reg;
    logic signed [15:0] z_floor_reg, z_ceil_reg;
    logic [8:0]         frac_reg;
    logic               mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_limit_reg <= 15'd20000;
            y_limit_reg <= 15'd20000;
            z_floor_reg <= -16'sd2000;
            z_ceil_reg  <= 16'sd3000;
            csx_reg     <= 15'd1250;
            csy_reg     <= 15'd1250;
            frac_reg    <= 9'd128;
            mode_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_X_LIMIT:   x_limit_reg <= cfg_wdata[14:0];
                REG_Y_LIMIT:   y_limit_reg <= cfg_wdata[14:0];
                REG_Z_FLOOR:   z_floor_reg <= cfg_wdata;
                REG_Z_CEILING: z_ceil_reg  <= cfg_wdata;
                REG_CELL_X:    csx_reg     <= cfg_wdata[14:0];
                REG_CELL_Y:    csy_reg     <= cfg_wdata[14:0];
                REG_FRACTION:  frac_reg    <= cfg_wdata[8:0];
                REG_MODE:      mode_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    state_t state_reg, state_next;

    // captured word
    logic signed [15:0] px_reg, py_reg, pz_reg;
    logic [7:0]         pi_reg;
    logic [CELL_AW-1:0] cell_reg;
    logic [CELL_AW-1:0] sweep_reg;

    // read walk
    logic [24:0]        prod_reg;
    logic signed [15:0] min_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic signed [18:0] thr_reg;
    logic [CNT_W-1:0]   idx_reg;
    pt_t                pend_reg;
    logic               pend_valid_reg;

    // memories
    stat_t              stat_mem [NCELLS];
    pt_t                pt_mem [PT_DEPTH];
    stat_t              stat_rdata_reg, stat_wdata;
    pt_t                pt_rdata_reg, pt_wdata;
    logic               stat_we, stat_re, pt_we, pt_re;
    logic [CELL_AW-1:0] stat_waddr, stat_raddr;
    logic [PT_AW-1:0]   pt_waddr, pt_raddr;

    always_ff @(posedge aclk) begin
        if (stat_we) stat_mem[stat_waddr] <= stat_wdata;
        if (stat_re) stat_rdata_reg <= stat_mem[stat_raddr];
    end

    always_ff @(posedge aclk) begin
        if (pt_we) pt_mem[pt_waddr] <= pt_wdata;
        if (pt_re) pt_rdata_reg <= pt_mem[pt_raddr];
    end

    // output register
    logic               m_valid_reg;
    kind_t              o_kind_reg;
    logic [1:0]         o_status_reg;
    logic [4:0]         o_row_reg, o_col_reg;
    pt_t                o_pt_reg;
    logic               o_last_reg;
    logic               out_load, out_free;
    kind_t              out_kind;
    logic [1:0]         out_status;
    logic [CELL_AW-1:0] out_cell;
    pt_t                out_pt;
    logic               out_last;

    assign out_free = !m_valid_reg || m_tready;

    // dividers for row and column
    logic               div_start, div_x_done, div_y_done;
    logic [15:0]        qx, qy;
    logic signed [16:0] sum_x, sum_y;
    logic [14:0]        den_x, den_y;

    assign sum_x = 17'(px_reg) + signed'({2'b00, x_limit_reg});
    assign sum_y = 17'(py_reg) + signed'({2'b00, y_limit_reg});
    assign den_x = (csx_reg == '0) ? 15'd1 : csx_reg;
    assign den_y = (csy_reg == '0) ? 15'd1 : csy_reg;

    gbh_div u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (sum_x[15:0]),
        .den     (den_x),
        .done    (div_x_done),
        .quo     (qx)
    );

    gbh_div u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (sum_y[15:0]),
        .den     (den_y),
        .done    (div_y_done),
        .quo     (qy)
    );

    // box check on the captured point
    logic signed [16:0] xs, ys, xl, yl;
    logic               reject;
    assign xs = 17'(px_reg);
    assign ys = 17'(py_reg);
    assign xl = signed'({2'b00, x_limit_reg});
    assign yl = signed'({2'b00, y_limit_reg});
    assign reject = (px_reg == '0) || (py_reg == '0) || (pz_reg == '0) ||
                    (xs < -xl) || (xs > xl) || (ys < -yl) || (ys > yl) ||
                    (pz_reg < z_floor_reg) || (pz_reg > z_ceil_reg);

    logic [CELL_AW-1:0] div_cell, rd_cell;
    logic               cell_full;
    logic               keep, rd_adv, rd_end;
    logic [PT_AW-1:0]   cell_base;
    logic signed [16:0] span;
    logic [15:0]        span_pos;

    assign div_cell  = {qx[GRID_BITS-1:0], qy[GRID_BITS-1:0]};
    assign rd_cell   = {GRID_BITS'(s_tdata[60:56]), GRID_BITS'(s_tdata[65:61])};
    assign cell_full = stat_rdata_reg.cnt >= CNT_W'(CELL_CAP);
    assign cell_base = PT_AW'(PT_AW'(cell_reg) * PT_AW'(CELL_CAP));
    assign keep      = 19'(signed'(pt_rdata_reg.z)) >= thr_reg;
    assign rd_end    = (idx_reg + 1'b1) == cnt_reg;
    assign span      = 17'(signed'(stat_rdata_reg.hmax)) - 17'(signed'(stat_rdata_reg.hmin));
    assign span_pos  = span[16] ? 16'd0 : span[15:0];

    assign s_tready = (state_reg == S_IDLE);

    // next state and control
    always_comb begin
        state_next      = state_reg;
        div_start       = 1'b0;
        stat_we         = 1'b0;
        stat_re         = 1'b0;
        stat_waddr      = cell_reg;
        stat_raddr      = cell_reg;
        stat_wdata      = stat_rdata_reg;
        pt_we           = 1'b0;
        pt_re           = 1'b0;
        pt_waddr        = cell_base + PT_AW'(stat_rdata_reg.cnt);
        pt_raddr        = cell_base + PT_AW'(idx_reg);
        pt_wdata        = '{inten: pi_reg, z: pz_reg, y: py_reg, x: px_reg};
        out_load        = 1'b0;
        out_kind        = KIND_STATUS;
        out_status      = INS_STORED;
        out_cell        = cell_reg;
        out_pt          = '0;
        out_last        = 1'b1;
        rd_adv          = 1'b0;
        unique case (state_reg)
            S_INIT, S_CLR: begin
                stat_we    = 1'b1;
                stat_waddr = sweep_reg;
                stat_wdata = '{cnt: '0, hmax: z_floor_reg, hmin: z_ceil_reg};
                if (sweep_reg == CELL_AW'(NCELLS - 1)) begin
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_CLR_DONE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    unique case (cmd_t'(s_tuser))
                        CMD_INSERT: state_next = S_INS_CHK;
                        CMD_READ: begin
                            stat_re    = 1'b1;
                            stat_raddr = rd_cell;
                            state_next = S_RD_MUL;
                        end
                        CMD_CLEAR: state_next = S_CLR;
                        default: ;
                    endcase
                end
            end
            S_INS_CHK: begin
                if (reject) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        out_status = INS_REJECT;
                        out_cell   = '0;
                        state_next = S_IDLE;
                    end
                end else begin
                    div_start  = 1'b1;
                    state_next = S_INS_DIV;
                end
            end
            S_INS_DIV: begin
                if (div_x_done && div_y_done) begin
                    stat_re    = 1'b1;
                    stat_raddr = div_cell;
                    state_next = S_INS_UPD;
                end
            end
            S_INS_UPD: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    if (cell_full) begin
                        out_status = INS_FULL;
                    end else begin
                        pt_we           = 1'b1;
                        stat_we         = 1'b1;
                        stat_wdata.cnt  = stat_rdata_reg.cnt + 1'b1;
                        if (pz_reg > signed'(stat_rdata_reg.hmax)) stat_wdata.hmax = pz_reg;
                        if (pz_reg < signed'(stat_rdata_reg.hmin)) stat_wdata.hmin = pz_reg;
                    end
                end
            end
            S_RD_MUL: state_next = S_RD_ADD;
            S_RD_ADD: state_next = (cnt_reg == '0) ? S_RD_FIN : S_RD_PT;
            S_RD_PT: begin
                pt_re      = 1'b1;
                state_next = S_RD_CHK;
            end
            S_RD_CHK: begin
                // a newer kept point releases the pending one as not last
                if (!(keep && pend_valid_reg && !out_free)) begin
                    rd_adv = 1'b1;
                    if (keep && pend_valid_reg) begin
                        out_load = 1'b1;
                        out_kind = KIND_POINT;
                        out_pt   = pend_reg;
                        out_last = 1'b0;
                    end
                    state_next = rd_end ? S_RD_FIN : S_RD_PT;
                end
            end
            S_RD_FIN: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_kind   = pend_valid_reg ? KIND_POINT : KIND_EMPTY;
                    out_pt     = pend_valid_reg ? pend_reg : '0;
                    state_next = S_IDLE;
                end
            end
            S_CLR_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_kind   = KIND_CLEAR;
                    out_cell   = '0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            sweep_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_INIT || state_reg == S_CLR) sweep_reg <= sweep_reg + 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            px_reg   <= s_tdata[15:0];
            py_reg   <= s_tdata[31:16];
            pz_reg   <= s_tdata[47:32];
            pi_reg   <= s_tdata[55:48];
            cell_reg <= rd_cell;
        end
        if (state_reg == S_INS_DIV && div_x_done && div_y_done) cell_reg <= div_cell;
        if (state_reg == S_RD_MUL) begin
            prod_reg <= 25'(span_pos) * 25'(frac_reg);
            min_reg  <= stat_rdata_reg.hmin;
            cnt_reg  <= stat_rdata_reg.cnt;
        end
        if (state_reg == S_RD_ADD) begin
            thr_reg <= mode_reg ? 19'sd0
                     : 19'(min_reg) + signed'({2'b00, prod_reg[24:8]});
            idx_reg <= '0;
        end
        if (rd_adv) begin
            idx_reg <= idx_reg + 1'b1;
            if (keep) pend_reg <= pt_rdata_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (state_reg == S_RD_ADD) begin
            pend_valid_reg <= 1'b0;
        end else if (rd_adv && keep) begin
            pend_valid_reg <= 1'b1;
        end
    end

    // result word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            o_kind_reg   <= out_kind;
            o_status_reg <= out_status;
            o_row_reg    <= 5'(out_cell[CELL_AW-1:GRID_BITS]);
            o_col_reg    <= 5'(out_cell[GRID_BITS-1:0]);
            o_pt_reg     <= out_pt;
            o_last_reg   <= out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {4'b0000, o_pt_reg.inten, o_pt_reg.z, o_pt_reg.y, o_pt_reg.x,
                       o_col_reg, o_row_reg, o_status_reg};

    // checks
    `GBH_ASSERT(a_status_last, aclk, aresetn,
        m_valid_reg && o_kind_reg == KIND_STATUS |-> o_last_reg,
        "insert status without last")
    `GBH_ASSERT(a_status_only_insert, aclk, aresetn,
        m_valid_reg && o_kind_reg != KIND_STATUS |-> o_status_reg == INS_STORED,
        "status code on non-insert result")
    `GBH_ASSERT(a_reject_no_cell, aclk, aresetn,
        m_valid_reg && o_kind_reg == KIND_STATUS && o_status_reg == INS_REJECT |->
        o_row_reg == '0 && o_col_reg == '0,
        "rejected insert names a cell")
    `GBH_ASSERT_ALWAYS(a_no_write_conflict, aclk,
        !(pt_we && (state_reg == S_INIT || state_reg == S_CLR)),
        "point write during sweep")

endmodule
`default_nettype wire
